// ===== rtl/drive_enable_sequencer_assert.svh =====
// Assertion macros for the drive enable sequencer
`ifndef DRIVE_ENABLE_SEQUENCER_ASSERT_SVH
`define DRIVE_ENABLE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define DES_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define DES_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/des_pkg.sv =====
// Package: types and constants of the drive enable sequencer
`timescale 1ns / 1ps
package des_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    localparam logic [2:0] REG_RESET_DELAY  = 3'd0;
    localparam logic [2:0] REG_INIT_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_READY_MASK   = 3'd2;
    localparam logic [2:0] REG_ON_MASK      = 3'd3;
    localparam logic [2:0] REG_OFF_MASK     = 3'd4;

    localparam logic [31:0] RESET_DELAY_RST  = 32'd100;
    localparam logic [31:0] INIT_TIMEOUT_RST = 32'd5000;
    localparam logic [15:0] READY_MASK_RST   = 16'd33;
    localparam logic [15:0] ON_MASK_RST      = 16'd39;
    localparam logic [15:0] OFF_MASK_RST     = 16'd64;

    localparam logic [15:0] CW_FAULT_RESET     = 16'h0080;
    localparam logic [15:0] CW_SHUTDOWN        = 16'h0006;
    localparam logic [15:0] CW_ENABLE_OP       = 16'h000F;
    localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;

    localparam logic [2:0] MS_OFF        = 3'd0;
    localparam logic [2:0] MS_SAFE_RESET = 3'd1;
    localparam logic [2:0] MS_PREPARE    = 3'd2;
    localparam logic [2:0] MS_SWITCH_ON  = 3'd3;
    localparam logic [2:0] MS_ON         = 3'd4;
    localparam logic [2:0] MS_FAULT      = 3'd5;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2
    } cmd_t;

    typedef enum logic [5:0] {
        S_OFF        = 6'b000001,
        S_SAFE_RESET = 6'b000010,
        S_PREPARE    = 6'b000100,
        S_SWITCH_ON  = 6'b001000,
        S_ON         = 6'b010000,
        S_FAULT      = 6'b100000
    } seq_state_t;

    typedef struct packed {
        logic                  kind;
        logic [15:0]           status_word;
        logic [1:0]            new_command;
        logic [TIME_WIDTH-1:0] time_now;
    } in_item_t;

    typedef struct packed {
        logic [15:0] control_word;
        logic [2:0]  motor_state;
        logic [1:0]  pending_command;
    } out_item_t;

    typedef struct packed {
        logic [31:0] reset_delay;
        logic [31:0] init_timeout;
        logic [15:0] ready_mask;
        logic [15:0] on_mask;
        logic [15:0] off_mask;
    } cfg_t;

    function automatic logic [2:0] motor_code(input seq_state_t s);
        logic [2:0] code;
        case (s)
            S_OFF:        code = MS_OFF;
            S_SAFE_RESET: code = MS_SAFE_RESET;
            S_PREPARE:    code = MS_PREPARE;
            S_SWITCH_ON:  code = MS_SWITCH_ON;
            S_ON:         code = MS_ON;
            S_FAULT:      code = MS_FAULT;
            default:      code = MS_OFF;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/des_apb_regs.sv =====
// Configuration register file behind the APB-style port
`timescale 1ns / 1ps
module des_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [des_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [des_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [des_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready,
    output des_pkg::cfg_t                   cfg
);
    import des_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_delay  <= RESET_DELAY_RST;
            cfg_reg.init_timeout <= INIT_TIMEOUT_RST;
            cfg_reg.ready_mask   <= READY_MASK_RST;
            cfg_reg.on_mask      <= ON_MASK_RST;
            cfg_reg.off_mask     <= OFF_MASK_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_RESET_DELAY:  cfg_reg.reset_delay  <= pwdata;
                REG_INIT_TIMEOUT: cfg_reg.init_timeout <= pwdata;
                REG_READY_MASK:   cfg_reg.ready_mask   <= pwdata[15:0];
                REG_ON_MASK:      cfg_reg.on_mask      <= pwdata[15:0];
                REG_OFF_MASK:     cfg_reg.off_mask     <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_RESET_DELAY:  prdata = cfg_reg.reset_delay;
            REG_INIT_TIMEOUT: prdata = cfg_reg.init_timeout;
            REG_READY_MASK:   prdata = {16'd0, cfg_reg.ready_mask};
            REG_ON_MASK:      prdata = {16'd0, cfg_reg.on_mask};
            REG_OFF_MASK:     prdata = {16'd0, cfg_reg.off_mask};
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/des_seq_core.sv =====
// Sequencer state and its one-item step logic
`timescale 1ns / 1ps
module des_seq_core (
    input  logic                clk,
    input  logic                rst_n,
    input  des_pkg::cfg_t       cfg,
    input  logic                step,
    input  des_pkg::in_item_t   item,
    output des_pkg::out_item_t  result
);
    import des_pkg::*;

    seq_state_t            state_reg, state_next, state_step;
    cmd_t                  cmd_reg, cmd_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;
    logic [15:0]           ctrl_reg, ctrl_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  timed_out;

    assign elapsed   = item.time_now - start_reg;
    // an item taken in off restarts the clock, so it cannot time out
    assign timed_out = (state_reg != S_OFF) && (elapsed > cfg.init_timeout);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        start_next = start_reg;
        ctrl_next  = ctrl_reg;
        state_step = state_reg;
        if (item.kind)
        begin
            case (item.new_command)
                CMD_ENABLE:  cmd_next = CMD_ENABLE;
                CMD_DISABLE: cmd_next = CMD_DISABLE;
                default:     cmd_next = CMD_NONE;
            endcase
        end
        else if (cmd_reg == CMD_ENABLE)
        begin
            case (state_reg)
                S_OFF:
                begin
                    start_next = item.time_now;
                    ctrl_next  = CW_FAULT_RESET;
                    state_step = S_SAFE_RESET;
                end
                S_SAFE_RESET:
                begin
                    ctrl_next = CW_SHUTDOWN;
                    if (elapsed > cfg.reset_delay)
                        state_step = S_PREPARE;
                end
                S_PREPARE:
                begin
                    ctrl_next = CW_SHUTDOWN;
                    if ((item.status_word & cfg.ready_mask) == cfg.ready_mask)
                        state_step = S_SWITCH_ON;
                end
                S_SWITCH_ON:
                begin
                    ctrl_next = CW_ENABLE_OP;
                    if ((item.status_word & cfg.on_mask) == cfg.on_mask)
                    begin
                        state_step = S_ON;
                        cmd_next   = CMD_NONE;
                    end
                end
                default: ;
            endcase
            state_next = state_step;
            if ((state_step == S_SAFE_RESET || state_step == S_PREPARE ||
                 state_step == S_SWITCH_ON) && timed_out)
                state_next = S_OFF;
        end
        else if (cmd_reg == CMD_DISABLE)
        begin
            ctrl_next = CW_DISABLE_VOLTAGE;
            if ((item.status_word & cfg.off_mask) == cfg.off_mask)
            begin
                state_next = S_OFF;
                cmd_next   = CMD_NONE;
            end
        end
    end

    assign result.control_word    = ctrl_next;
    assign result.motor_state     = motor_code(state_next);
    assign result.pending_command = cmd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_OFF;
            cmd_reg   <= CMD_NONE;
            start_reg <= '0;
            ctrl_reg  <= CW_DISABLE_VOLTAGE;
        end
        else if (step)
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            start_reg <= start_next;
            ctrl_reg  <= ctrl_next;
        end
    end

endmodule

// ===== rtl/drive_enable_sequencer.sv =====
// Drive enable sequencer: top level with input and result registers
//
// Usage:
//   req channel (req_valid / req_stall / req): one item per handshake.
//     kind 1 sets the pending command, kind 0 is a status update with a
//     timestamp that steps the enable or disable sequence.
//   rsp channel (rsp_valid / rsp_stall / rsp): exactly one item per request,
//     in order: control word, motor state and pending command after the item.
//   APB-style port: reset_delay, init_timeout, ready_mask, on_mask, off_mask
//     at byte addresses 0, 4, 8, 12, 16; write only while idle.
// Timing:
//   an accepted item passes the input register, then the result register;
//   one item per cycle is sustained while results are not stalled, set by
//   the single registered step between input and result registers.
// Reset:
//   state off, command none, control word disable voltage, registers at
//   their defaults, both pipeline registers empty.
// Stall:
//   a stalled result holds; the input register still takes one more item,
//   then req_stall rises until the result is taken.
`timescale 1ns / 1ps
module drive_enable_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  des_pkg::in_item_t               req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output des_pkg::out_item_t              rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [des_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [des_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [des_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);
    import des_pkg::*;

    `include "drive_enable_sequencer_assert.svh"

    cfg_t      cfg;
    in_item_t  stage_reg;
    logic      stage_valid_reg;
    out_item_t step_result;
    out_item_t rsp_reg;
    logic      rsp_valid_reg;
    logic      advance;
    logic      step;

    des_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    des_seq_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (stage_reg),
        .result (step_result)
    );

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign step      = stage_valid_reg && advance;
    assign req_stall = stage_valid_reg && !advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                stage_valid_reg <= req_valid;
                rsp_valid_reg   <= stage_valid_reg;
            end
            else if (!stage_valid_reg)
                stage_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            stage_reg <= req;
        if (step)
            rsp_reg <= step_result;
    end

    `DES_ASSERT_IMPL(a_stall_only_full, req_stall, stage_valid_reg)
    `DES_ASSERT_NEXT(a_held_result_stays, rsp_valid && rsp_stall, rsp_valid)
    `DES_ASSERT_IMPL(a_no_fault_state, rsp_valid, rsp.motor_state <= MS_ON)

endmodule

// ===== tb/tb_drive_enable_sequencer.sv =====
// Self-checking testbench for the drive enable sequencer: directed table, then random phases
`timescale 1ns / 1ps
module tb_drive_enable_sequencer;
    import des_pkg::*;

    localparam logic      KIND_UPDATE  = 1'b0;
    localparam logic      KIND_COMMAND = 1'b1;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t reply;
    } dir_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    in_item_t              req       = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    out_item_t             rsp;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr     = '0;
    logic [DATA_WIDTH-1:0] pwdata    = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    drive_enable_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // predictor state and register mirror
    cfg_t        cfg;
    logic [2:0]  drv_state;
    cmd_t        drv_cmd;
    logic [31:0] drv_start;
    logic [15:0] drv_ctrl;
    logic [15:0] drv_status;

    out_item_t   replies_due[$];
    dir_row_t    dir_rows[$];
    logic [31:0] tick;
    int          errors     = 0;
    int          n_sent     = 0;
    int          n_checked  = 0;
    int          n_on       = 0;
    int          n_restart  = 0;
    int          cycles     = 0;
    int          hold_rsp   = 0;
    int          send_burst = 0;
    bit          send_calm  = 1'b0;
    bit          rsp_calm   = 1'b0;

    function automatic void enable_advance(input logic [31:0] now);
        logic [31:0] elapsed;
        case (drv_state)
            MS_OFF:
            begin
                drv_start = now;
                drv_ctrl  = CW_FAULT_RESET;
                drv_state = MS_SAFE_RESET;
            end
            MS_SAFE_RESET:
            begin
                drv_ctrl = CW_SHUTDOWN;
                elapsed  = now - drv_start;
                if (elapsed > cfg.reset_delay)
                    drv_state = MS_PREPARE;
            end
            MS_PREPARE:
            begin
                drv_ctrl = CW_SHUTDOWN;
                if ((drv_status & cfg.ready_mask) == cfg.ready_mask)
                    drv_state = MS_SWITCH_ON;
            end
            MS_SWITCH_ON:
            begin
                drv_ctrl = CW_ENABLE_OP;
                if ((drv_status & cfg.on_mask) == cfg.on_mask)
                begin
                    drv_state = MS_ON;
                    drv_cmd   = CMD_NONE;
                    n_on++;
                end
            end
            default: ;
        endcase
        elapsed = now - drv_start;
        if ((drv_state inside {MS_SAFE_RESET, MS_PREPARE, MS_SWITCH_ON}) &&
            elapsed > cfg.init_timeout)
        begin
            drv_state = MS_OFF;
            n_restart++;
        end
    endfunction

    function automatic out_item_t step_sequence(input in_item_t it);
        out_item_t r;
        if (it.kind == KIND_COMMAND)
        begin
            // unused code three is held as no command
            drv_cmd = (it.new_command inside {CMD_ENABLE, CMD_DISABLE}) ?
                      cmd_t'(it.new_command) : CMD_NONE;
        end
        else
        begin
            drv_status = it.status_word;
            if (drv_cmd == CMD_ENABLE)
                enable_advance(it.time_now);
            else if (drv_cmd == CMD_DISABLE)
            begin
                drv_ctrl = CW_DISABLE_VOLTAGE;
                if ((drv_status & cfg.off_mask) == cfg.off_mask)
                begin
                    drv_state = MS_OFF;
                    drv_cmd   = CMD_NONE;
                end
            end
        end
        r.control_word    = drv_ctrl;
        r.motor_state     = drv_state;
        r.pending_command = drv_cmd;
        return r;
    endfunction

    function automatic int idle_draw(inout bit calm);
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic dir_row_t row(input logic k, input logic [15:0] s,
                                     input logic [1:0] c, input logic [31:0] t,
                                     input bit chk = 1'b0,
                                     input logic [15:0] cw = '0,
                                     input logic [2:0] ms = '0,
                                     input logic [1:0] pc = '0);
        dir_row_t d;
        d.item.kind        = k;
        d.item.status_word = s;
        d.item.new_command = c;
        d.item.time_now    = t;
        d.typed            = chk;
        d.reply.control_word    = cw;
        d.reply.motor_state     = ms;
        d.reply.pending_command = pc;
        return d;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       r;
        it.kind        = ($urandom_range(0, 99) < 18) ? KIND_COMMAND : KIND_UPDATE;
        it.status_word = 16'($urandom_range(0, 16'hFFFF));
        case ($urandom_range(0, 3))
            1: it.status_word |= cfg.ready_mask | cfg.on_mask | cfg.off_mask;
            2: it.status_word |= cfg.ready_mask;
            3: it.status_word &= 16'($urandom);
            default: ;
        endcase
        r = $urandom_range(0, 19);
        if (r < 10)
            it.new_command = CMD_ENABLE;
        else if (r < 15)
            it.new_command = CMD_DISABLE;
        else if (r < 18)
            it.new_command = CMD_NONE;
        else
            it.new_command = CMD_UNUSED;
        if ($urandom_range(0, 63) == 0)
            tick = $urandom;
        else
            tick = tick + 32'($urandom_range(0, 60));
        it.time_now = tick;
        return it;
    endfunction

    task automatic push_item(input in_item_t it, input bit typed, input out_item_t fixed);
        int        gap;
        out_item_t p;
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        p = step_sequence(it);
        replies_due.push_back(typed ? fixed : p);
        n_sent++;
        if (send_burst > 0)
        begin
            send_burst--;
            gap = 0;
        end
        else
            gap = idle_draw(send_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_replies(input int extra);
        req_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_RESET_DELAY:  cfg.reset_delay  = val;
            REG_INIT_TIMEOUT: cfg.init_timeout = val;
            REG_READY_MASK:   cfg.ready_mask   = val[15:0];
            REG_ON_MASK:      cfg.on_mask      = val[15:0];
            REG_OFF_MASK:     cfg.off_mask     = val[15:0];
            default: ;
        endcase
    endtask

    task automatic check_reply(input out_item_t got);
        out_item_t want;
        if (replies_due.size() == 0)
        begin
            $error("result with nothing expected: %h", got);
            errors++;
        end
        else
        begin
            want = replies_due.pop_front();
            n_checked++;
            if (got.control_word !== want.control_word)
            begin
                $error("control_word: expected %h, got %h", want.control_word, got.control_word);
                errors++;
            end
            if (got.motor_state !== want.motor_state)
            begin
                $error("motor_state: expected %0d, got %0d", want.motor_state, got.motor_state);
                errors++;
            end
            if (got.pending_command !== want.pending_command)
            begin
                $error("pending_command: expected %0d, got %0d",
                       want.pending_command, got.pending_command);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_drive_enable_sequencer: errors");
            $finish;
        end
    end

    initial
    begin : result_side
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            n = idle_draw(rsp_calm);
            if (hold_rsp > 0)
            begin
                n = hold_rsp;
                hold_rsp = 0;
            end
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            check_reply(rsp);
        end
    end

    initial
    begin : stimulus
        cfg_t plan [PHASES];
        cfg.reset_delay  = RESET_DELAY_RST;
        cfg.init_timeout = INIT_TIMEOUT_RST;
        cfg.ready_mask   = READY_MASK_RST;
        cfg.on_mask      = ON_MASK_RST;
        cfg.off_mask     = OFF_MASK_RST;
        drv_state  = MS_OFF;
        drv_cmd    = CMD_NONE;
        drv_start  = '0;
        drv_ctrl   = CW_DISABLE_VOLTAGE;
        drv_status = '0;
        tick       = '0;

        plan[0] = '{RESET_DELAY_RST, INIT_TIMEOUT_RST, READY_MASK_RST, ON_MASK_RST,
                    OFF_MASK_RST};
        plan[1] = '{32'd0, 32'd0, 16'h0000, 16'h0000, 16'h0000};
        plan[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        plan[3] = '{32'd0, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000};
        for (int p = 4; p < PHASES; p++)
        begin
            plan[p].reset_delay  = $urandom_range(0, 150);
            plan[p].init_timeout = $urandom_range(100, 3000);
            plan[p].ready_mask   = 16'($urandom & $urandom);
            plan[p].on_mask      = 16'($urandom & $urandom);
            plan[p].off_mask     = 16'($urandom & $urandom);
        end

        // walk-through at reset settings: idle updates, unused code, disable,
        // full enable with wrapped time, set-command mid-sequence, init timeout
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'h0, 1'b1,
                               CW_DISABLE_VOLTAGE, MS_OFF, CMD_NONE));
        dir_rows.push_back(row(KIND_UPDATE, 16'hFFFF, CMD_UNUSED, 32'hFFFF_FFFF, 1'b1,
                               CW_DISABLE_VOLTAGE, MS_OFF, CMD_NONE));
        dir_rows.push_back(row(KIND_COMMAND, 16'hFFFF, CMD_UNUSED, 32'hFFFF_FFFF, 1'b1,
                               CW_DISABLE_VOLTAGE, MS_OFF, CMD_NONE));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_DISABLE, 32'h0, 1'b1,
                               CW_DISABLE_VOLTAGE, MS_OFF, CMD_DISABLE));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0040, CMD_NONE, 32'h0, 1'b1,
                               CW_DISABLE_VOLTAGE, MS_OFF, CMD_NONE));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_ENABLE, 32'h0, 1'b1,
                               CW_DISABLE_VOLTAGE, MS_OFF, CMD_ENABLE));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'hFFFF_FFF0, 1'b1,
                               CW_FAULT_RESET, MS_SAFE_RESET, CMD_ENABLE));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'h0000_0054));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'h0000_0055));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0020, CMD_NONE, 32'h0000_0060));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0021, CMD_NONE, 32'h0000_0061));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_NONE, 32'h0));
        dir_rows.push_back(row(KIND_UPDATE, 16'hFFFF, CMD_NONE, 32'h0000_0062));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_ENABLE, 32'h0));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0023, CMD_NONE, 32'h0000_0063));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0027, CMD_NONE, 32'h0000_0064));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_ENABLE, 32'h0));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'h7000_0000));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_DISABLE, 32'h0));
        dir_rows.push_back(row(KIND_UPDATE, 16'hFFBF, CMD_NONE, 32'h0));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0040, CMD_NONE, 32'h0));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_ENABLE, 32'h0));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'd1000));
        dir_rows.push_back(row(KIND_UPDATE, 16'h0000, CMD_NONE, 32'd6001));
        dir_rows.push_back(row(KIND_COMMAND, 16'h0000, CMD_NONE, 32'h0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].reply);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_replies(4);
            write_reg(REG_RESET_DELAY,  plan[p].reset_delay);
            write_reg(REG_INIT_TIMEOUT, plan[p].init_timeout);
            write_reg(REG_READY_MASK,   {16'h0, plan[p].ready_mask});
            write_reg(REG_ON_MASK,      {16'h0, plan[p].on_mask});
            write_reg(REG_OFF_MASK,     {16'h0, plan[p].off_mask});
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (p == 1 && i == 20)
                begin
                    // long result back-pressure while items keep coming
                    hold_rsp   = 60;
                    send_burst = 16;
                end
                if (p == 3 && i == 75)
                    drain_replies(0);
                push_item(random_item(), 1'b0, '0);
            end
        end

        drain_replies(10);
        $display("covered %0d items over %0d register settings, %0d results checked",
                 n_sent, PHASES + 1, n_checked);
        $display("enable sequences completed %0d, init timeout restarts %0d",
                 n_on, n_restart);
        if (errors == 0)
            $display("tb_drive_enable_sequencer: clean");
        else
            $display("tb_drive_enable_sequencer: errors");
        $finish;
    end

endmodule
